// ===== rtl/lbfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lbfd_pkg
// Shared types and constants of the load based frequency decision core.
// ----------------------------------------------------------------------------
package lbfd_pkg;

  localparam int TIME_W     = 32;
  localparam int LOAD_W     = 7;
  localparam int THR_W      = 7;
  localparam int MULT_W     = 17;
  localparam int PEAK_W     = 32;
  localparam int DIV_NUM_W  = TIME_W + LOAD_W;
  localparam int DIV_DEN_W  = TIME_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int ACTION_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_UP_THR         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_DIFF      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLING_DOWN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IO_BUSY        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NICE_IDLE      = 3'd4;

  localparam logic [THR_W-1:0]  UP_THR_RST        = 7'd60;
  localparam logic [THR_W-1:0]  DOWN_DIFF_RST     = 7'd20;
  localparam logic [MULT_W-1:0] DOWN_FACTOR_MIN   = 17'd1;
  localparam logic [MULT_W-1:0] DOWN_FACTOR_MAX   = 17'd100000;

  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RAISE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOWER = 2'd2;

  localparam logic REL_LOW_AT_OR_ABOVE  = 1'b0;
  localparam logic REL_HIGH_AT_OR_BELOW = 1'b1;

  typedef struct packed {
    logic [THR_W-1:0]  up_thr;
    logic [THR_W-1:0]  down_margin;
    logic [MULT_W-1:0] down_factor;
    logic              io_busy;
    logic              nice_idle;
    logic              down_factor_written;
  } cfg_t;

endpackage

// ===== rtl/lbfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lbfd_cfg_regs
// Configuration register file with range clamping of the sampling down factor.
// ----------------------------------------------------------------------------
module lbfd_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lbfd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lbfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output lbfd_pkg::cfg_t                    cfg_o
);
  import lbfd_pkg::*;

  logic [THR_W-1:0]  up_q, up_d;
  logic [THR_W-1:0]  down_q, down_d;
  logic [MULT_W-1:0] sdf_q, sdf_d;
  logic              io_q, io_d;
  logic              nice_q, nice_d;
  logic              sdf_wr_q, sdf_wr_d;
  logic [MULT_W-1:0] sdf_clamped;
  logic              wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_comb begin
    sdf_clamped = cfg_data_i[MULT_W-1:0];
    if (sdf_clamped == '0) begin
      sdf_clamped = DOWN_FACTOR_MIN;
    end else if (sdf_clamped > DOWN_FACTOR_MAX) begin
      sdf_clamped = DOWN_FACTOR_MAX;
    end
  end

  always_comb begin
    up_d     = up_q;
    down_d   = down_q;
    sdf_d    = sdf_q;
    io_d     = io_q;
    nice_d   = nice_q;
    sdf_wr_d = 1'b0;
    if (wr) begin
      unique case (cfg_index_i)
        REG_UP_THR:        up_d   = cfg_data_i[THR_W-1:0];
        REG_DOWN_DIFF:     down_d = cfg_data_i[THR_W-1:0];
        REG_SAMPLING_DOWN: begin
          sdf_d    = sdf_clamped;
          sdf_wr_d = 1'b1;
        end
        REG_IO_BUSY:       io_d   = cfg_data_i[0];
        REG_NICE_IDLE:     nice_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q     <= UP_THR_RST;
      down_q   <= DOWN_DIFF_RST;
      sdf_q    <= DOWN_FACTOR_MIN;
      io_q     <= 1'b0;
      nice_q   <= 1'b0;
      sdf_wr_q <= 1'b0;
    end else begin
      up_q     <= up_d;
      down_q   <= down_d;
      sdf_q    <= sdf_d;
      io_q     <= io_d;
      nice_q   <= nice_d;
      sdf_wr_q <= sdf_wr_d;
    end
  end

  assign cfg_o.up_thr              = up_q;
  assign cfg_o.down_margin         = down_q;
  assign cfg_o.down_factor         = sdf_q;
  assign cfg_o.io_busy             = io_q;
  assign cfg_o.nice_idle           = nice_q;
  assign cfg_o.down_factor_written = sdf_wr_q;

endmodule

// ===== rtl/lbfd_serial_div.sv =====
// ----------------------------------------------------------------------------
// lbfd_serial_div
// Restoring long divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lbfd_serial_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [lbfd_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [lbfd_pkg::DIV_DEN_W-1:0]   den_i,
  output logic                             busy_o,
  output logic [lbfd_pkg::DIV_NUM_W-1:0]   quo_o
);
  import lbfd_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] shf_q, shf_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [DIV_DEN_W:0]   rem_ext;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  assign rem_ext = {rem_q, shf_q[DIV_NUM_W-1]};
  assign ge      = rem_ext >= {1'b0, den_q};
  assign rem_sub = rem_ext - {1'b0, den_q};

  always_comb begin
    shf_d  = shf_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      shf_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(DIV_NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      shf_d = {shf_q[DIV_NUM_W-2:0], ge};
      rem_d = ge ? rem_sub[DIV_DEN_W-1:0] : rem_ext[DIV_DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = shf_q;

endmodule

// ===== rtl/load_based_frequency_decision_core.sv =====
// ----------------------------------------------------------------------------
// load_based_frequency_decision_core
// Per CPU load sampling with a running peak of load times frequency, and one
// raise, lower or hold decision at the end of each sampling period.
// ----------------------------------------------------------------------------
// A counted sample runs the 39 step serial load division before the core is
// idle again; a skipped sample that is not a last one returns after the check.
// A last sample then runs the raise test, the lowering test when that fails,
// and a division of the peak to lower; its decision is valid back in idle.
// A decision not yet taken by the receiver holds the next decision in the core.
// Reset is asynchronous: defaults return, the peak clears, the multiplier is one.
module load_based_frequency_decision_core #(
  parameter int  FREQ_BITS   = 22,
  localparam int IN_W        = 4 * lbfd_pkg::TIME_W + 4 * FREQ_BITS,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = lbfd_pkg::ACTION_W + FREQ_BITS + 1 + lbfd_pkg::MULT_W,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lbfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lbfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // wall_delta, idle_delta, iowait_delta, nice_delta, avg_freq, cur_freq,
  // min_freq, max_freq
  input  logic [IN_TDATA_W-1:0]           s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // action, target_freq, relation, rate_multiplier
  output logic [OUT_TDATA_W-1:0]          m_axis_tdata_o
);
  import lbfd_pkg::*;

  localparam int PROD_W = THR_W + FREQ_BITS;
  localparam int LF_W   = LOAD_W + FREQ_BITS;
  localparam int FB     = FREQ_BITS;
  localparam int T4     = 4 * TIME_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NICE  = 4'd1;
  localparam logic [3:0] ST_IOW   = 4'd2;
  localparam logic [3:0] ST_CHK   = 4'd3;
  localparam logic [3:0] ST_SCALE = 4'd4;
  localparam logic [3:0] ST_DIV1  = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_PEAK  = 4'd7;
  localparam logic [3:0] ST_UPM   = 4'd8;
  localparam logic [3:0] ST_UPT   = 4'd9;
  localparam logic [3:0] ST_DNT   = 4'd10;
  localparam logic [3:0] ST_DIV2  = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  cfg_t cfg;

  logic [3:0]            state_q, state_d;
  logic [TIME_W-1:0]     wall_q, iow_q, nice_q, busy_q;
  logic [TIME_W:0]       idle_q;
  logic [FB-1:0]         avg_q, cur_q, min_q, max_q;
  logic                  last_q;
  logic [LOAD_W-1:0]     load_q;
  logic [LF_W-1:0]       lf_q;
  logic [PROD_W-1:0]     prod_q;
  logic [PEAK_W-1:0]     peak_q;
  logic [MULT_W-1:0]     imult_q;
  logic [ACTION_W-1:0]   action_q;
  logic [FB-1:0]         target_q;
  logic                  rel_q;
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;

  logic                  accept;
  logic                  div_start;
  logic                  div_busy;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_DEN_W-1:0]  div_den;
  logic [DIV_NUM_W-1:0]  div_quo;
  logic [THR_W-1:0]      diff;
  logic [FB-1:0]         avg_sel;
  logic [FB-1:0]         quo_low;
  logic                  out_free;

  lbfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lbfd_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign diff            = cfg.up_thr - cfg.down_margin;
  assign avg_sel         = (avg_q == '0) ? cur_q : avg_q;
  assign quo_low         = div_quo[FB-1:0];

  assign div_start = (state_q == ST_SCALE) ||
                     ((state_q == ST_DNT) && (peak_q < PEAK_W'(prod_q)));

  // Busy time times 100 is formed as 64x + 32x + 4x.
  always_comb begin
    if (state_q == ST_SCALE) begin
      div_num = (DIV_NUM_W'(busy_q) << 6) + (DIV_NUM_W'(busy_q) << 5) +
                (DIV_NUM_W'(busy_q) << 2);
      div_den = wall_q;
    end else begin
      div_num = DIV_NUM_W'(peak_q);
      div_den = DIV_DEN_W'(diff);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_NICE;
      ST_NICE:  state_d = ST_IOW;
      ST_IOW:   state_d = ST_CHK;
      ST_CHK: begin
        if ((wall_q != '0) && ({1'b0, wall_q} >= idle_q)) begin
          state_d = ST_SCALE;
        end else begin
          state_d = last_q ? ST_UPM : ST_IDLE;
        end
      end
      ST_SCALE: state_d = ST_DIV1;
      ST_DIV1:  if (!div_busy) state_d = ST_MUL;
      ST_MUL:   state_d = ST_PEAK;
      ST_PEAK:  state_d = last_q ? ST_UPM : ST_IDLE;
      ST_UPM:   state_d = ST_UPT;
      ST_UPT: begin
        if (peak_q > PEAK_W'(prod_q)) begin
          state_d = ST_OUT;
        end else if ((cur_q != min_q) && (cfg.up_thr > cfg.down_margin)) begin
          state_d = ST_DNT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DNT:   state_d = div_start ? ST_DIV2 : ST_OUT;
      ST_DIV2:  if (!div_busy) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      peak_q      <= '0;
      imult_q     <= DOWN_FACTOR_MIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg.down_factor_written) begin
        imult_q <= DOWN_FACTOR_MIN;
      end
      if ((state_q == ST_PEAK) && (PEAK_W'(lf_q) > peak_q)) begin
        peak_q <= PEAK_W'(lf_q);
      end
      if ((state_q == ST_UPT) && (peak_q > PEAK_W'(prod_q)) && (cur_q < max_q)) begin
        imult_q <= cfg.down_factor;
      end
      if ((state_q == ST_DIV2) && !div_busy) begin
        imult_q <= DOWN_FACTOR_MIN;
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
        peak_q      <= '0;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wall_q   <= s_axis_tdata_i[TIME_W-1:0];
      idle_q   <= {1'b0, s_axis_tdata_i[2*TIME_W-1:TIME_W]};
      iow_q    <= s_axis_tdata_i[3*TIME_W-1:2*TIME_W];
      nice_q   <= s_axis_tdata_i[T4-1:3*TIME_W];
      avg_q    <= s_axis_tdata_i[T4+FB-1:T4];
      cur_q    <= s_axis_tdata_i[T4+2*FB-1:T4+FB];
      min_q    <= s_axis_tdata_i[T4+3*FB-1:T4+2*FB];
      max_q    <= s_axis_tdata_i[T4+4*FB-1:T4+3*FB];
      last_q   <= s_axis_tlast_i;
      action_q <= ACT_NONE;
      target_q <= '0;
      rel_q    <= REL_LOW_AT_OR_ABOVE;
    end
    if ((state_q == ST_NICE) && cfg.nice_idle) begin
      idle_q <= idle_q + {1'b0, nice_q};
    end
    if ((state_q == ST_IOW) && cfg.io_busy && (idle_q >= {1'b0, iow_q})) begin
      idle_q <= idle_q - {1'b0, iow_q};
    end
    if (state_q == ST_CHK) begin
      busy_q <= wall_q - idle_q[TIME_W-1:0];
    end
    if ((state_q == ST_DIV1) && !div_busy) begin
      load_q <= div_quo[LOAD_W-1:0];
    end
    if (state_q == ST_MUL) begin
      lf_q <= LF_W'(load_q) * LF_W'(avg_sel);
    end
    if (state_q == ST_UPM) begin
      prod_q <= PROD_W'(cfg.up_thr) * PROD_W'(cur_q);
    end
    if (state_q == ST_UPT) begin
      prod_q <= PROD_W'(diff) * PROD_W'(cur_q);
      if ((peak_q > PEAK_W'(prod_q)) && (cur_q != max_q)) begin
        action_q <= ACT_RAISE;
        target_q <= max_q;
        rel_q    <= REL_HIGH_AT_OR_BELOW;
      end
    end
    if ((state_q == ST_DIV2) && !div_busy) begin
      action_q <= ACT_LOWER;
      target_q <= (quo_low < min_q) ? min_q : quo_low;
      rel_q    <= REL_LOW_AT_OR_ABOVE;
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_data_q <= {imult_q, rel_q, target_q, action_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_data_q);

endmodule
